// ===== design/q2e_pkg.sv =====
// Shared constants, types and tables for the quaternion to Euler angle unit.
`default_nettype none
package q2e_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 29;
  localparam int LANE_W       = 40;
  localparam int ANG_W        = 34;
  localparam int RAD_W        = 57;
  localparam int ROOT_W       = RAD_W + 1;
  localparam int STEP_W       = 5;
  localparam int RES_W        = 17;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [RES_W-1:0] PI_Q13      = 17'sd25736;
  localparam logic signed [RES_W-1:0] HALF_PI_Q13 = 17'sd12868;

  typedef enum logic [1:0] {
    SAT_NONE,
    SAT_POS,
    SAT_NEG
  } sat_e;

  typedef struct packed {
    logic signed [LANE_W-1:0] x;
    logic signed [LANE_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
    logic                     zero;
  } lane_t;

  typedef struct packed {
    lane_t              roll;
    lane_t              pitch;
    lane_t              yaw;
    logic [RAD_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
    sat_e               sat;
  } item_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] a;
    case (i)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      5'd12: a = 34'sd262144;
      5'd13: a = 34'sd131072;
      5'd14: a = 34'sd65536;
      5'd15: a = 34'sd32768;
      5'd16: a = 34'sd16384;
      5'd17: a = 34'sd8192;
      5'd18: a = 34'sd4096;
      5'd19: a = 34'sd2048;
      5'd20: a = 34'sd1024;
      5'd21: a = 34'sd512;
      5'd22: a = 34'sd256;
      5'd23: a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== design/q2e_front.sv =====
// Front end: component products, the three arctangent arguments and the pitch radicand.
`default_nettype none
module q2e_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic signed [15:0]  quat_w_i,
  input  wire logic signed [15:0]  quat_x_i,
  input  wire logic signed [15:0]  quat_y_i,
  input  wire logic signed [15:0]  quat_z_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output q2e_pkg::item_t           out_item_o
);
  import q2e_pkg::*;

  localparam int SW = 35;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  logic signed [SW-1:0] sr_q, cr_q, sp_q, sy_q, cy_q;
  logic signed [SW-1:0] sr_d, cr_d, sp_d, sy_d, cy_d;
  sat_e sat2_q, sat2_d;
  item_t item_q, item_d;
  logic signed [28:0] sp29;
  logic signed [57:0] sq;
  logic [57:0] rad;

  function automatic lane_t prerotate(input logic signed [SW-1:0] y,
                                      input logic signed [SW-1:0] x);
    lane_t l;
    logic signed [LANE_W-1:0] xe, ye;
    xe = LANE_W'(x);
    ye = LANE_W'(y);
    l.zero = (x == '0) && (y == '0);
    l.x = xe;
    l.y = ye;
    l.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.x = ye;
        l.y = -xe;
        l.z = HALF_PI_Q30;
      end else begin
        l.x = -ye;
        l.y = xe;
        l.z = -HALF_PI_Q30;
      end
    end
    return l;
  endfunction

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign out_valid_o = v3_q;
  assign out_item_o = item_q;

  always_comb begin
    sr_d = (SW'(wx_q) + SW'(yz_q)) <<< 1;
    cr_d = 35'sd268435456 - ((SW'(xx_q) + SW'(yy_q)) <<< 1);
    sp_d = (SW'(wy_q) - SW'(zx_q)) <<< 1;
    sy_d = (SW'(wz_q) + SW'(xy_q)) <<< 1;
    cy_d = 35'sd268435456 - ((SW'(yy_q) + SW'(zz_q)) <<< 1);
    if (sp_d >= 35'sd268435456) begin
      sat2_d = SAT_POS;
    end else if (sp_d <= -35'sd268435456) begin
      sat2_d = SAT_NEG;
    end else begin
      sat2_d = SAT_NONE;
    end
  end

  always_comb begin
    sp29 = $signed(sp_q[28:0]);
    sq = 58'(sp29 * sp29);
    rad = (58'd1 << 56) - $unsigned(sq);
    item_d.roll = prerotate(sr_q, cr_q);
    item_d.yaw = prerotate(sy_q, cy_q);
    item_d.pitch.x = '0;
    item_d.pitch.y = LANE_W'(sp_q);
    item_d.pitch.z = '0;
    item_d.pitch.zero = 1'b0;
    item_d.rem = rad[RAD_W-1:0];
    item_d.root = '0;
    item_d.sat = sat2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      wy_q <= quat_w_i * quat_y_i;
      zx_q <= quat_z_i * quat_x_i;
    end
    if (rdy2) begin
      sr_q <= sr_d;
      cr_q <= cr_d;
      sp_q <= sp_d;
      sy_q <= sy_d;
      cy_q <= cy_d;
      sat2_q <= sat2_d;
    end
    if (rdy3) item_q <= item_d;
  end

endmodule
`default_nettype wire

// ===== design/q2e_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root for the pitch cosine.
`default_nettype none
module q2e_sqrt_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [q2e_pkg::STEP_W-1:0]    step_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire q2e_pkg::item_t                in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output q2e_pkg::item_t                     out_item_o
);
  import q2e_pkg::*;

  logic valid_q;
  item_t item_q, item_d;
  logic [ROOT_W-1:0] bit_w;
  logic [ROOT_W:0] trial;

  assign in_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o = item_q;

  always_comb begin
    bit_w = ROOT_W'(1) << {step_i, 1'b0};
    trial = (ROOT_W+1)'(in_item_i.root) + (ROOT_W+1)'(bit_w);
    item_d = in_item_i;
    if ((ROOT_W+1)'(in_item_i.rem) >= trial) begin
      item_d.rem = in_item_i.rem - trial[RAD_W-1:0];
      item_d.root = (in_item_i.root >> 1) + bit_w;
    end else begin
      item_d.root = in_item_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) item_q <= item_d;
  end

endmodule
`default_nettype wire

// ===== design/q2e_cordic_cell.sv =====
// One micro-rotation cell of the vectoring CORDIC, applied to all three angle lanes.
`default_nettype none
module q2e_cordic_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [q2e_pkg::STEP_W-1:0]    step_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire q2e_pkg::item_t                in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output q2e_pkg::item_t                     out_item_o
);
  import q2e_pkg::*;

  logic valid_q;
  item_t item_q, item_d;

  function automatic lane_t rotate(input lane_t l, input logic [STEP_W-1:0] i);
    lane_t r;
    logic signed [LANE_W-1:0] dx, dy;
    logic signed [ANG_W-1:0] a;
    dx = $signed(l.y) >>> i;
    dy = $signed(l.x) >>> i;
    a = atan_q30(i);
    r = l;
    if (l.y >= 0) begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + a;
    end else begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - a;
    end
    return r;
  endfunction

  assign in_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o = item_q;

  always_comb begin
    item_d = in_item_i;
    item_d.roll = rotate(in_item_i.roll, step_i);
    item_d.pitch = rotate(in_item_i.pitch, step_i);
    item_d.yaw = rotate(in_item_i.yaw, step_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) item_q <= item_d;
  end

endmodule
`default_nettype wire

// ===== design/q2e_back.sv =====
// Output stage: rounds the accumulated angles, applies clamps and pitch saturation.
`default_nettype none
module q2e_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire q2e_pkg::item_t in_item_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic signed [15:0]  roll_angle_o,
  output logic signed [14:0]  pitch_angle_o,
  output logic signed [15:0]  yaw_angle_o
);
  import q2e_pkg::*;

  logic valid_q;
  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;
  logic signed [RES_W-1:0] roll_d, pitch_d, yaw_d;

  function automatic logic signed [RES_W-1:0] finish(input lane_t l,
                                                     input logic signed [RES_W-1:0] lim);
    logic signed [ANG_W-1:0] s;
    logic signed [RES_W-1:0] r;
    s = (l.z + 34'sd65536) >>> 17;
    if (l.zero) begin
      r = '0;
    end else if (s > ANG_W'(lim)) begin
      r = lim;
    end else if (s < -ANG_W'(lim)) begin
      r = -lim;
    end else begin
      r = s[RES_W-1:0];
    end
    return r;
  endfunction

  assign in_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign roll_angle_o = roll_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o = yaw_q;

  always_comb begin
    roll_d = finish(in_item_i.roll, PI_Q13);
    yaw_d = finish(in_item_i.yaw, PI_Q13);
    case (in_item_i.sat)
      SAT_POS: pitch_d = HALF_PI_Q13;
      SAT_NEG: pitch_d = -HALF_PI_Q13;
      default: pitch_d = finish(in_item_i.pitch, HALF_PI_Q13);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      roll_q <= roll_d[15:0];
      pitch_q <= pitch_d[14:0];
      yaw_q <= yaw_d[15:0];
    end
  end

endmodule
`default_nettype wire

// ===== design/quaternion_to_euler_unit.sv =====
// Top level of the quaternion to Z-Y-X Euler angle unit.
// Each beat carries one quaternion in Q1.14 and produces one beat of roll and yaw in Q2.13
// radians and pitch in Q1.13 radians. The unit is a chain of pipeline cells: three front
// stages for products and arguments, 29 square-root digit cells for the pitch cosine, 16
// CORDIC micro-rotation cells shared by all three angles, and one output register. A new
// beat is accepted every cycle unless the pipeline back-pressures the input; each cell moves
// on as soon as the cell after it has room, so stalls at the output compress bubbles and
// back-pressure reaches the input only when every cell is full.
`default_nettype none
module quaternion_to_euler_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic signed [15:0]  quat_w_i,
  input  wire logic signed [15:0]  quat_x_i,
  input  wire logic signed [15:0]  quat_y_i,
  input  wire logic signed [15:0]  quat_z_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [15:0]       roll_angle_o,
  output logic signed [14:0]       pitch_angle_o,
  output logic signed [15:0]       yaw_angle_o
);
  import q2e_pkg::*;

  item_t sq_item [SQRT_STEPS+1];
  logic  sq_valid [SQRT_STEPS+1];
  logic  sq_ready [SQRT_STEPS+1];
  item_t co_item [CORDIC_STEPS+1];
  logic  co_valid [CORDIC_STEPS+1];
  logic  co_ready [CORDIC_STEPS+1];
  item_t co_head;

  q2e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .quat_w_i    (quat_w_i),
    .quat_x_i    (quat_x_i),
    .quat_y_i    (quat_y_i),
    .quat_z_i    (quat_z_i),
    .out_valid_o (sq_valid[0]),
    .out_ready_i (sq_ready[0]),
    .out_item_o  (sq_item[0])
  );

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (STEP_W'(SQRT_STEPS - 1 - j)),
      .in_valid_i  (sq_valid[j]),
      .in_ready_o  (sq_ready[j]),
      .in_item_i   (sq_item[j]),
      .out_valid_o (sq_valid[j+1]),
      .out_ready_i (sq_ready[j+1]),
      .out_item_o  (sq_item[j+1])
    );
  end

  always_comb begin
    co_head = sq_item[SQRT_STEPS];
    co_head.pitch.x = LANE_W'(sq_item[SQRT_STEPS].root);
  end
  assign co_item[0] = co_head;
  assign co_valid[0] = sq_valid[SQRT_STEPS];
  assign sq_ready[SQRT_STEPS] = co_ready[0];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    q2e_cordic_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (STEP_W'(k)),
      .in_valid_i  (co_valid[k]),
      .in_ready_o  (co_ready[k]),
      .in_item_i   (co_item[k]),
      .out_valid_o (co_valid[k+1]),
      .out_ready_i (co_ready[k+1]),
      .out_item_o  (co_item[k+1])
    );
  end

  q2e_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (co_valid[CORDIC_STEPS]),
    .in_ready_o    (co_ready[CORDIC_STEPS]),
    .in_item_i     (co_item[CORDIC_STEPS]),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .roll_angle_o  (roll_angle_o),
    .pitch_angle_o (pitch_angle_o),
    .yaw_angle_o   (yaw_angle_o)
  );

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled although the output stage is empty");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_angle_o <= 15'sd12868) && (pitch_angle_o >= -15'sd12868))
    else $error("pitch beat outside plus or minus half pi");

  a_roll_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (roll_angle_o <= 16'sd25736) && (roll_angle_o >= -16'sd25736) &&
                    (yaw_angle_o <= 16'sd25736) && (yaw_angle_o >= -16'sd25736))
    else $error("roll or yaw beat outside plus or minus pi");

endmodule
`default_nettype wire

// ===== test/quaternion_to_euler_unit_tb.sv =====
// Self-checking testbench for the quaternion to Z-Y-X Euler angle unit.
`timescale 1ns / 1ps
module quaternion_to_euler_unit_tb;

  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  localparam int NUM_STEPS = 16;
  localparam longint UNIT_Q28 = 64'sd1 << 28;
  localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
  localparam longint HALF_TURN_Q13 = 25736;
  localparam longint QUARTER_TURN_Q13 = 12868;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] roll_angle_o;
  logic signed [14:0] pitch_angle_o;
  logic signed [15:0] yaw_angle_o;

  quat_t pending_quats[$];
  euler_t expected_angles[$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int saturated_pitches = 0;
  bit hold_receiver = 1'b0;
  bit sender_paused = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  quaternion_to_euler_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint arctan_step(int i);
    case (i)
      0: return 843314857;
      1: return 497837829;
      2: return 263043837;
      3: return 133525159;
      4: return 67021687;
      5: return 33543516;
      6: return 16775851;
      7: return 8388437;
      8: return 4194283;
      9: return 2097149;
      default: return 64'sd1 << (30 - i);
    endcase
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint ang;
    longint t;
    longint dx;
    longint dy;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; ang = QUARTER_TURN_Q30;
      end else begin
        xv = -yv; yv = t; ang = -QUARTER_TURN_Q30;
      end
    end
    for (int i = 0; i < NUM_STEPS; i++) begin
      dx = floor_shift(yv, i);
      dy = floor_shift(xv, i);
      if (yv >= 0) begin
        xv += dx; yv -= dy; ang += arctan_step(i);
      end else begin
        xv -= dx; yv += dy; ang -= arctan_step(i);
      end
    end
    return floor_shift(ang + (64'sd1 << 16), 17);
  endfunction

  function automatic longint clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic euler_t convert_quat(quat_t q);
    euler_t e;
    longint w, x, y, z, sp, c;
    w = q.w; x = q.x; y = q.y; z = q.z;
    e.roll = 16'(clamp(vector_angle(2 * (w * x + y * z), UNIT_Q28 - 2 * (x * x + y * y)),
        HALF_TURN_Q13));
    sp = 2 * (w * y - z * x);
    if (sp >= UNIT_Q28) e.pitch = 15'(QUARTER_TURN_Q13);
    else if (sp <= -UNIT_Q28) e.pitch = 15'(-QUARTER_TURN_Q13);
    else begin
      c = root_floor((64'd1 << 56) - longint'(sp * sp));
      e.pitch = 15'(clamp(vector_angle(sp, c), QUARTER_TURN_Q13));
    end
    e.yaw = 16'(clamp(vector_angle(2 * (w * z + x * y), UNIT_Q28 - 2 * (y * y + z * z)),
        HALF_TURN_Q13));
    return e;
  endfunction

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic quat_t unit_quat();
    quat_t q;
    real a, b, c, d, n;
    a = $itor($signed($urandom_range(0, 2000)) - 1000);
    b = $itor($signed($urandom_range(0, 2000)) - 1000);
    c = $itor($signed($urandom_range(0, 2000)) - 1000);
    d = $itor($signed($urandom_range(0, 2000)) - 1000);
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) begin
      a = 1.0; n = 1.0;
    end
    q.w = 16'($rtoi(a / n * 16384.0));
    q.x = 16'($rtoi(b / n * 16384.0));
    q.y = 16'($rtoi(c / n * 16384.0));
    q.z = 16'($rtoi(d / n * 16384.0));
    return q;
  endfunction

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
    return q;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    quat_t q;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_angles.push_back(convert_quat(pending_quats.pop_front()));
        beats_sent <= beats_sent + 1;
      end
      if (in_valid_i && !in_ready_o) begin
      end else if (pending_quats.size() > 0 && !sender_paused && gap_left == 0) begin
        q = pending_quats[0];
        in_valid_i <= 1'b1;
        quat_w_i <= q.w; quat_x_i <= q.x; quat_y_i <= q.y; quat_z_i <= q.z;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // Receiver: stalls on its own pattern and checks each result beat.
  always @(posedge clk_i) begin
    euler_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected result beat roll %0d pitch %0d yaw %0d", $time,
              roll_angle_o, pitch_angle_o, yaw_angle_o);
          errors++;
        end else begin
          e = expected_angles.pop_front();
          if (e.pitch == 15'(QUARTER_TURN_Q13) || e.pitch == 15'(-QUARTER_TURN_Q13))
            saturated_pitches++;
          if (roll_angle_o !== e.roll) begin
            $display("%0t: roll expected %0d actual %0d", $time, e.roll, roll_angle_o);
            errors++;
          end
          if (pitch_angle_o !== e.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch_angle_o);
            errors++;
          end
          if (yaw_angle_o !== e.yaw) begin
            $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, yaw_angle_o);
            errors++;
          end
        end
        beats_checked++;
      end
      if (hold_receiver) out_ready_i <= 1'b0;
      else if ((beats_checked / 64) % 2 == 0) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    int pause_cycles;
    pending_quats.push_back(make_quat(16384, 0, 0, 0));
    pending_quats.push_back(make_quat(0, 0, 0, 0));
    pending_quats.push_back(make_quat(0, 16384, 0, 0));
    pending_quats.push_back(make_quat(0, 0, 16384, 0));
    pending_quats.push_back(make_quat(0, 0, 0, 16384));
    pending_quats.push_back(make_quat(-16384, -16384, -16384, -16384));
    pending_quats.push_back(make_quat(16384, 16384, 16384, 16384));
    pending_quats.push_back(make_quat(11585, 0, 11585, 0));
    pending_quats.push_back(make_quat(11585, 0, -11585, 0));
    pending_quats.push_back(make_quat(11585, 11585, 0, 0));
    pending_quats.push_back(make_quat(-32768, 32767, -32768, 32767));
    pending_quats.push_back(make_quat(32767, -32768, 32767, -32768));
    pending_quats.push_back(make_quat(0, 8192, 0, 0));
    pending_quats.push_back(make_quat(0, 0, 11585, 11585));
    pending_quats.push_back(make_quat(100, 0, 0, 0));
    pending_quats.push_back(make_quat(16384, 0, 1, 0));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 150; i++)
      pending_quats.push_back(($urandom_range(0, 4) != 0) ? unit_quat() :
          make_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
    // Long receiver hold-off so the pipeline fills and back-pressures the input.
    hold_receiver = 1'b1;
    pause_cycles = 0;
    while (pause_cycles < 200) begin
      @(posedge clk_i);
      pause_cycles++;
    end
    hold_receiver = 1'b0;
    wait (pending_quats.size() == 0);
    sender_paused = 1'b1;
    wait (expected_angles.size() == 0);
    sender_paused = 1'b0;
    for (int i = 0; i < 300; i++)
      pending_quats.push_back(($urandom_range(0, 4) != 0) ? unit_quat() :
          make_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
    wait (pending_quats.size() == 0 && !in_valid_i);
    wait (expected_angles.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d quaternion beats and checked %0d result beats.", beats_sent,
        beats_checked);
    $display("%0d results had a saturated pitch.", saturated_pitches);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/q2e_pkg.sv
design/q2e_front.sv
design/q2e_sqrt_cell.sv
design/q2e_cordic_cell.sv
design/q2e_back.sv
design/quaternion_to_euler_unit.sv
test/quaternion_to_euler_unit_tb.sv
